@@ src/mt19937_ranged_random_defines.svh @@
// Assertion macros shared by the checker.
// No dependencies.
`ifndef MT19937_RANGED_RANDOM_DEFINES_SVH
`define MT19937_RANGED_RANDOM_DEFINES_SVH
// implication checked every clock, muted during reset
`define MTR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MTR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/mtr_pkg.sv @@
// Package for the bounded MT19937 generator: constants and tempering.
// No dependencies.
`default_nettype none
package mtr_pkg;
    localparam int unsigned MtWords = 624;
    localparam int unsigned MtShift = 397;
    localparam int unsigned IdxW = 10;
    localparam logic [31:0] MtMatrix   = 32'h9908b0df;
    localparam logic [31:0] MtInitMult = 32'd1812433253;
    localparam logic [31:0] MtTemperB  = 32'h9d2c5680;
    localparam logic [31:0] MtTemperC  = 32'hefc60000;
    localparam logic [31:0] MtResetSeed = 32'd5489;

    function automatic logic [31:0] mt_temper(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & MtTemperB);
        w = w ^ ((w << 15) & MtTemperC);
        w = w ^ (w >> 18);
        return w;
    endfunction
endpackage
`default_nettype wire

@@ src/mt19937_ranged_random.sv @@
// Bounded MT19937: one result per transfer, lower + word mod span.
// Each transfer passes read, temper, 32-step remainder and output before m_valid;
// a full-range request skips the remainder. No new request is taken until m_valid clears.
// After every 624 items the state is re-twisted, in states RA, RB, RC, WR per word.
// After reset or a seed write the state is rebuilt: an init sweep plus a full
// twist, during which s_ready stays low. Reset seed is 5489.
// Depends on mtr_pkg and mtr_divider.
`default_nettype none
module mt19937_ranged_random
    import mtr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_low_bound,
    input  wire logic signed [31:0] s_high_bound,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_random_value
);
    typedef enum logic [3:0] {
        ST_INIT_MUL, ST_INIT_WR, ST_TW_RA, ST_TW_RB, ST_TW_RC, ST_TW_WR,
        ST_IDLE, ST_READ, ST_TEMPER, ST_DIV, ST_OUT
    } state_t;

    // state memory: one write port, one registered read port
    logic [31:0] mem [MtWords];
    logic [31:0] rd_data_reg;
    logic [IdxW-1:0] rd_addr;
    logic        wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [31:0] wr_data;

    state_t      state_reg;
    logic [IdxW-1:0] idx_reg;      // init/twist sweep index
    logic [IdxW:0]   pos_reg;      // next word to temper, 624 means twist due
    logic [31:0] prev_reg;         // init recurrence previous word (seed for word 0)
    logic [31:0] prod_reg;         // registered multiply
    logic [31:0] nxt_reg, far_reg; // twist operands
    logic [31:0] lo_reg, span_reg, word_reg;
    logic        div_start;
    logic        div_done;
    logic [31:0] div_rem;
    logic [31:0] out_reg;
    logic        outv_reg;

    function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                                input logic [IdxW-1:0] b);
        logic [IdxW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IdxW+1)'(MtWords)) s = s - (IdxW+1)'(MtWords);
        return s[IdxW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // memory addressing from the sequencer
    // twist reads: RA -> next word (seen in RB), RB -> far word (seen in RC),
    // RC -> current word (seen in WR)
    always_comb begin
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = (idx_reg == '0) ? prev_reg : prod_reg + 32'(idx_reg);
        unique case (state_reg)
            ST_TW_RA: rd_addr = wrap_add(idx_reg, IdxW'(1));
            ST_TW_RB: rd_addr = wrap_add(idx_reg, IdxW'(MtShift));
            ST_TW_RC: rd_addr = idx_reg;
            ST_INIT_WR: wr_en = 1'b1;
            ST_TW_WR: begin
                wr_en = 1'b1;
                wr_data = far_reg
                        ^ ({rd_data_reg[31], nxt_reg[30:0]} >> 1)
                        ^ (nxt_reg[0] ? MtMatrix : 32'd0);
            end
            ST_IDLE:  rd_addr = pos_reg[IdxW-1:0];
            default: ;
        endcase
    end

    logic swap;
    logic [31:0] lo_sel, hi_sel;
    always_comb begin
        swap   = s_low_bound > s_high_bound;
        lo_sel = swap ? s_high_bound : s_low_bound;
        hi_sel = swap ? s_low_bound  : s_high_bound;
    end

    assign s_ready        = (state_reg == ST_IDLE) && !outv_reg
                            && (pos_reg != (IdxW+1)'(MtWords)) && !seed_we;
    assign m_valid        = outv_reg;
    assign m_random_value = out_reg;
    assign div_start      = (state_reg == ST_TEMPER) && (span_reg != 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT_WR;
            idx_reg   <= '0;
            pos_reg   <= '0;
            outv_reg  <= 1'b0;
            prod_reg  <= '0;
            prev_reg  <= MtResetSeed;
        end else begin
            if (outv_reg && m_ready) outv_reg <= 1'b0;
            if (seed_we) begin
                // restart: word 0 is the seed itself
                state_reg <= ST_INIT_WR;
                idx_reg   <= '0;
                pos_reg   <= '0;
                prev_reg  <= seed_wdata;
            end else begin
                unique case (state_reg)
                    ST_INIT_MUL: begin
                        prod_reg  <= MtInitMult * (prev_reg ^ (prev_reg >> 30));
                        state_reg <= ST_INIT_WR;
                    end
                    ST_INIT_WR: begin
                        prev_reg <= wr_data;
                        if (idx_reg == IdxW'(MtWords - 1)) begin
                            idx_reg   <= '0;
                            state_reg <= ST_TW_RA;
                        end else begin
                            idx_reg   <= idx_reg + IdxW'(1);
                            state_reg <= ST_INIT_MUL;
                        end
                    end
                    ST_TW_RA: state_reg <= ST_TW_RB;
                    ST_TW_RB: begin
                        nxt_reg   <= rd_data_reg;
                        state_reg <= ST_TW_RC;
                    end
                    ST_TW_RC: begin
                        far_reg   <= rd_data_reg;
                        state_reg <= ST_TW_WR;
                    end
                    ST_TW_WR: begin
                        if (idx_reg == IdxW'(MtWords - 1)) begin
                            idx_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + IdxW'(1);
                            state_reg <= ST_TW_RA;
                        end
                    end
                    ST_IDLE: begin
                        if (pos_reg == (IdxW+1)'(MtWords) && !outv_reg) begin
                            idx_reg   <= '0;
                            state_reg <= ST_TW_RA;
                        end else if (s_valid && s_ready) begin
                            lo_reg    <= lo_sel;
                            span_reg  <= hi_sel - lo_sel + 32'd1;
                            pos_reg   <= pos_reg + (IdxW+1)'(1);
                            state_reg <= ST_READ;
                        end
                    end
                    ST_READ: begin
                        // word read at the transfer edge is here now
                        word_reg  <= mt_temper(rd_data_reg);
                        state_reg <= ST_TEMPER;
                    end
                    ST_TEMPER: begin
                        if (span_reg == 32'd0) begin
                            out_reg   <= word_reg;
                            outv_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                    ST_DIV: if (div_done) state_reg <= ST_OUT;
                    ST_OUT: begin
                        out_reg   <= lo_reg + div_rem;
                        outv_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    mtr_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (word_reg),
        .divisor   (span_reg),
        .done      (div_done),
        .remainder (div_rem)
    );
endmodule
`default_nettype wire

@@ src/mtr_divider.sv @@
// Iterative 32-bit unsigned remainder, one quotient bit per cycle.
// Standalone, no package dependencies.
`default_nettype none
module mtr_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;

    always_comb begin
        trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
        if (!trial[32]) begin
            rem_next = trial[31:0];
        end else begin
            rem_next = {rem_reg[30:0], quo_reg[31]};
        end
        quo_next = {quo_reg[30:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end
    assign remainder = rem_reg;
endmodule
`default_nettype wire

@@ src/mtr_checker.sv @@
// Port-level checker for the bounded MT19937 block, bound to the top level.
// Depends on mt19937_ranged_random_defines.svh.
`include "mt19937_ranged_random_defines.svh"
`default_nettype none
module mtr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_random_value
);
    `MTR_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_random_value), "result changed while stalled")
    `MTR_ASSERT_IMP(a_busy, aclk, aresetn, m_valid, !s_ready, "took item with result pending")
    `MTR_ASSERT_NXT(a_seq, aclk, aresetn, s_valid && s_ready, !s_ready && !m_valid, "overlapping items")
endmodule
bind mt19937_ranged_random mtr_checker u_chk (.*);
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for mt19937_ranged_random: bounded MT19937 draws and seed writes.
// A local twister model predicts each value; a table of directed requests precedes random traffic.
// Depends on mtr_pkg (reset seed) and the RTL under src/.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mtr_pkg::*;

    localparam int N_WORDS   = 624;
    localparam int N_SHIFT   = 397;
    localparam int N_RANDOM  = 1500;
    localparam longint LIMIT = 64'd3000000;
    localparam int SETTLE    = 3000;   // idle wait after the last drain, before the verdict

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        seed_we = 1'b0;
    logic [31:0] seed_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_low_bound = '0;
    logic signed [31:0] s_high_bound = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_random_value;

    mt19937_ranged_random dut (
        .aclk(aclk), .aresetn(aresetn),
        .seed_we(seed_we), .seed_wdata(seed_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_low_bound(s_low_bound), .s_high_bound(s_high_bound),
        .m_valid(m_valid), .m_ready(m_ready), .m_random_value(m_random_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---- twister model ----------------------------------------------------
    logic [31:0] mt_state [N_WORDS];
    int          mt_pos;

    function automatic void mt_reseed(input logic [31:0] s);
        logic [31:0] prev;
        logic [31:0] y;
        logic [31:0] v;
        mt_state[0] = s;
        for (int i = 1; i < N_WORDS; i++) begin
            prev = mt_state[i-1];
            mt_state[i] = 32'd1812433253 * (prev ^ (prev >> 30)) + i;
        end
        // twist done in place, in index order (later words see updated early ones)
        for (int i = 0; i < N_WORDS; i++) begin
            y = (mt_state[i] & 32'h8000_0000) | (mt_state[(i+1) % N_WORDS] & 32'h7fff_ffff);
            v = mt_state[(i+N_SHIFT) % N_WORDS] ^ (y >> 1);
            if (y[0]) v = v ^ 32'h9908_b0df;
            mt_state[i] = v;
        end
        mt_pos = 0;
    endfunction

    function automatic void mt_twist();
        logic [31:0] y;
        logic [31:0] v;
        for (int i = 0; i < N_WORDS; i++) begin
            y = (mt_state[i] & 32'h8000_0000) | (mt_state[(i+1) % N_WORDS] & 32'h7fff_ffff);
            v = mt_state[(i+N_SHIFT) % N_WORDS] ^ (y >> 1);
            if (y[0]) v = v ^ 32'h9908_b0df;
            mt_state[i] = v;
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] bounded_draw(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] w;
        logic [31:0] span;
        lo = a;
        hi = b;
        if ($signed(lo) > $signed(hi)) begin
            lo = b;
            hi = a;
        end
        if (mt_pos >= N_WORDS) mt_twist();
        w = mt_state[mt_pos];
        mt_pos++;
        // standard tempering
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & 32'h9d2c_5680);
        w = w ^ ((w << 15) & 32'hefc6_0000);
        w = w ^ (w >> 18);
        span = hi - lo + 32'd1;
        if (span == 32'd0) return w;    // full 32-bit range: raw word
        return lo + (w % span);
    endfunction

    // ---- scoreboard -------------------------------------------------------
    logic [31:0] pending_values [$];
    int          n_errors = 0;
    longint      cycle = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          recv_hold = 1'b0;
    int          hold_cycles = 0;

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("[mt19937_ranged_random] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (recv_hold && hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_values.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %h at cycle %0d", m_random_value, cycle);
            end else begin
                want = pending_values.pop_front();
                if (m_random_value !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("random_value mismatch: exp %h got %h", want, m_random_value);
                end
            end
        end
    end

    // one request; predicted value is queued on acceptance.
    // valid stays up after the transfer until an idle gap or drain drops it.
    task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                                input bit has_known, input logic [31:0] known);
        logic [31:0] pred;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_low_bound <= a;
        s_high_bound <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = bounded_draw(a, b);
        if (has_known && pred !== known) begin
            n_errors++;
            if (n_errors <= 10) $display("table row disagrees: exp %h model %h", known, pred);
        end
        pending_values.push_back(has_known ? known : pred);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        drain();
        seed_we <= 1'b1;
        seed_wdata <= s;
        @(posedge aclk);
        seed_we <= 1'b0;
        mt_reseed(s);
    endtask

    // directed table; known values only for seed 5489 full-range draws and single-value ranges
    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        bit          known;
        logic [31:0] value;
    } request_row_t;

    request_row_t directed_rows [15] = '{
        '{32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'd3499211612},  // full range, first draw
        '{32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'd581869302},   // full range, reversed
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},   // single value
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
        '{32'h0000_0000, 32'h0000_0009, 1'b0, 32'h0},
        '{32'h0000_0009, 32'h0000_0000, 1'b0, 32'h0},           // reversed bounds
        '{32'hffff_fff6, 32'h0000_000a, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h7fff_ffff, 1'b0, 32'h0},
        '{32'h8000_0001, 32'h7fff_ffff, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h7fff_fffe, 1'b0, 32'h0},
        '{32'hffff_ffff, 32'h0000_0000, 1'b0, 32'h0},
        '{32'h5555_5555, 32'haaaa_aaaa, 1'b0, 32'h0},
        '{32'h0000_0001, 32'h0000_0002, 1'b0, 32'h0}
    };

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(200) - 100;
            2: return {1'($urandom_range(1)), 31'($urandom())};
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    initial begin
        int plan_idle [4] = '{0, 52, 0, 30};
        int plan_stall [4] = '{0, 0, 52, 30};
        logic [31:0] seeds [4] = '{32'd0, 32'hffff_ffff, 32'd1, 32'h1234_5678};
        mt_reseed(MtResetSeed);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].known, directed_rows[i].value);

        // long receiver hold-off while the sender keeps offering
        drain();
        hold_cycles <= 400;
        recv_hold <= 1'b1;
        for (int k = 0; k < 20; k++) send_request(pick_bound(), pick_bound(), 1'b0, 0);
        drain();
        recv_hold <= 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            // reseed every other phase so each pair of phases crosses a re-twist
            if (ph % 2 == 0) write_seed(seeds[ph]);
            send_idle_pct = plan_idle[ph];
            recv_stall_pct = plan_stall[ph];
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_request(pick_bound(), pick_bound(), 1'b0, 0);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_seed(MtResetSeed);
        send_request(32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'd3499211612);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (n_errors == 0) begin
            $display("[mt19937_ranged_random] OK");
        end else begin
            $display("[mt19937_ranged_random] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
